>>> rtl/ptp_meta_frame_filter_defines.svh
// Assertion macros for the PTP META frame filter checker.
`ifndef PTP_META_FRAME_FILTER_DEFINES_SVH
`define PTP_META_FRAME_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PTP_MFF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptp_mff check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PTP_MFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptp_mff check failed");

`endif

>>> rtl/ptp_mff_pkg.sv
// Shared types and constants of the PTP META frame filter.
package ptp_mff_pkg;

   localparam int MAC_W      = 48;
   localparam int VID_W      = 12;
   localparam int ETYPE_W    = 16;
   localparam int TAG_W      = 16;
   localparam int NS_W       = 30;
   localparam int SEC_W      = 32;
   localparam int ACTION_W   = 3;
   localparam int DEBT_OUT_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [ETYPE_W-1:0] PTP_ETHERTYPE = 16'h88F7;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_META_SRC    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MGMT_MASK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MGMT_MATCH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PTP_VLAN_ID = 3'd4;

   localparam logic [ACTION_W-1:0] ACT_PASS      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INVALID   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_META_Q    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_PKT_Q     = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_META_FULL = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_PKT_FULL  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_BAD_VLAN  = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_FLUSHED   = 3'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Classified header as passed from the front end to the back end.
   typedef struct packed {
      logic             flush;
      logic             active;
      logic             meta;
      logic             mgmt;
      logic             ptp;
      logic             vlan_ok;
      logic             meta_full;
      logic             pkt_full;
      logic [NS_W-1:0]  nanoseconds;
      logic [SEC_W-1:0] seconds;
   } frame_class_type;

endpackage

>>> rtl/ptp_meta_frame_filter.sv
// Top level of the PTP META frame filter: front end, header queue and back end.
//
//   Channel  Direction  Handshake                 Carries
//   req_     in         req_valid / req_stall     one header or a flush request
//   rsp_     out        rsp_valid / rsp_stall     one routing decision per request
//   csr_     in         csr_write_enable          register writes, no read-back
//
// One request per cycle is sustained while rsp_stall is low; a result passes through the header
// queue and then the response register before it can be taken.
// The debt counter in the back end is updated once per decision.
// Reset is synchronous and clears the queue, the debt counter, the response valid flag
// and all configuration registers.
// A stalled response holds the back end; the four-entry queue keeps taking requests
// until it fills, and then req_stall rises.
module ptp_meta_frame_filter
   import ptp_mff_pkg::*;
#(
   parameter int DEBT_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [MAC_W-1:0]      req_dst_mac,
   input  logic [MAC_W-1:0]      req_src_mac,
   input  logic [ETYPE_W-1:0]    req_len_type,
   input  logic                  req_vlan_present,
   input  logic [TAG_W-1:0]      req_vlan_tci,
   input  logic                  req_meta_queue_full,
   input  logic                  req_packet_queue_full,
   input  logic [NS_W-1:0]       req_rx_nanoseconds,
   input  logic [SEC_W-1:0]      req_rx_seconds,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_consumed,
   output logic [ACTION_W-1:0]   rsp_action,
   output logic                  rsp_flush_queues,
   output logic [NS_W-1:0]       rsp_stamp_nanoseconds,
   output logic [SEC_W-1:0]      rsp_stamp_seconds,
   output logic [DEBT_OUT_W-1:0] rsp_debt_after
);

   frame_class_type front_class;
   frame_class_type queue_head;
   logic            queue_full;
   logic            queue_not_empty;
   logic            queue_push;
   logic            queue_pop;

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   ptp_mff_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_func              (req_func),
      .req_dst_mac           (req_dst_mac),
      .req_src_mac           (req_src_mac),
      .req_len_type          (req_len_type),
      .req_vlan_present      (req_vlan_present),
      .req_vlan_tci          (req_vlan_tci),
      .req_meta_queue_full   (req_meta_queue_full),
      .req_packet_queue_full (req_packet_queue_full),
      .req_rx_nanoseconds    (req_rx_nanoseconds),
      .req_rx_seconds        (req_rx_seconds),
      .class_out             (front_class)
   );

   ptp_mff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_class),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   ptp_mff_back #(
      .DEBT_WIDTH (DEBT_WIDTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .item_valid            (queue_not_empty),
      .item                  (queue_head),
      .item_pop              (queue_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_consumed          (rsp_consumed),
      .rsp_action            (rsp_action),
      .rsp_flush_queues      (rsp_flush_queues),
      .rsp_stamp_nanoseconds (rsp_stamp_nanoseconds),
      .rsp_stamp_seconds     (rsp_stamp_seconds),
      .rsp_debt_after        (rsp_debt_after)
   );

endmodule

>>> rtl/ptp_mff_front.sv
// Front end: configuration registers and header classification.
module ptp_mff_front
   import ptp_mff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_func,
   input  logic [MAC_W-1:0]      req_dst_mac,
   input  logic [MAC_W-1:0]      req_src_mac,
   input  logic [ETYPE_W-1:0]    req_len_type,
   input  logic                  req_vlan_present,
   input  logic [TAG_W-1:0]      req_vlan_tci,
   input  logic                  req_meta_queue_full,
   input  logic                  req_packet_queue_full,
   input  logic [NS_W-1:0]       req_rx_nanoseconds,
   input  logic [SEC_W-1:0]      req_rx_seconds,
   output frame_class_type       class_out
);

   logic             enable_ff;
   logic [MAC_W-1:0] meta_src_ff;
   logic [MAC_W-1:0] mgmt_mask_ff;
   logic [MAC_W-1:0] mgmt_match_ff;
   logic [VID_W-1:0] vlan_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         meta_src_ff   <= '0;
         mgmt_mask_ff  <= '0;
         mgmt_match_ff <= '0;
         vlan_id_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE:      enable_ff     <= csr_wdata[0];
            CSR_META_SRC:    meta_src_ff   <= csr_wdata[MAC_W-1:0];
            CSR_MGMT_MASK:   mgmt_mask_ff  <= csr_wdata[MAC_W-1:0];
            CSR_MGMT_MATCH:  mgmt_match_ff <= csr_wdata[MAC_W-1:0];
            CSR_PTP_VLAN_ID: vlan_id_ff    <= csr_wdata[VID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      class_out.flush       = req_func;
      class_out.active      = enable_ff;
      class_out.meta        = (req_src_mac == meta_src_ff);
      class_out.mgmt        = ((req_dst_mac & mgmt_mask_ff) == mgmt_match_ff);
      class_out.ptp         = (req_len_type == PTP_ETHERTYPE);
      class_out.vlan_ok     = !req_vlan_present || (req_vlan_tci[VID_W-1:0] == vlan_id_ff);
      class_out.meta_full   = req_meta_queue_full;
      class_out.pkt_full    = req_packet_queue_full;
      class_out.nanoseconds = req_rx_nanoseconds;
      class_out.seconds     = req_rx_seconds;
   end

endmodule

>>> rtl/ptp_mff_queue.sv
// Short queue of classified headers between the front and back ends.
module ptp_mff_queue
   import ptp_mff_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  frame_class_type push_data,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output frame_class_type head
);

   frame_class_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;
   logic [QCNT_W-1:0]    count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/ptp_mff_back.sv
// Back end: routing decision, META debt counter and the response register.
module ptp_mff_back
   import ptp_mff_pkg::*;
#(
   parameter int DEBT_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  frame_class_type       item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_consumed,
   output logic [ACTION_W-1:0]   rsp_action,
   output logic                  rsp_flush_queues,
   output logic [NS_W-1:0]       rsp_stamp_nanoseconds,
   output logic [SEC_W-1:0]      rsp_stamp_seconds,
   output logic [DEBT_OUT_W-1:0] rsp_debt_after
);

   logic [DEBT_WIDTH-1:0] debt_ff;
   logic [DEBT_WIDTH-1:0] debt_in;
   logic [DEBT_WIDTH-1:0] debt_inc;
   logic                  debt_nonzero;
   logic                  invalid;

   logic                  valid_ff;
   logic                  consumed_ff;
   logic                  consumed_in;
   logic [ACTION_W-1:0]   action_ff;
   logic [ACTION_W-1:0]   action_in;
   logic                  flush_ff;
   logic                  flush_in;
   logic [NS_W-1:0]       ns_ff;
   logic [NS_W-1:0]       ns_in;
   logic [SEC_W-1:0]      sec_ff;
   logic [SEC_W-1:0]      sec_in;
   logic [DEBT_WIDTH+DEBT_OUT_W-1:0] debt_wide;

   // The response register takes a new decision when it is empty or being drained.
   assign item_pop = item_valid && (!valid_ff || !rsp_stall);

   assign debt_nonzero = (debt_ff != '0);
   assign debt_inc     = (debt_ff == '1) ? debt_ff : debt_ff + 1'b1;
   assign invalid      = (item.meta && debt_nonzero) || (item.meta && item.mgmt) ||
                         (item.meta && item.ptp) || (item.mgmt != item.ptp);

   always_comb begin
      debt_in     = debt_ff;
      consumed_in = 1'b0;
      action_in   = ACT_PASS;
      flush_in    = 1'b0;
      ns_in       = '0;
      sec_in      = '0;
      if (item.flush) begin
         debt_in   = '0;
         action_in = ACT_FLUSHED;
         flush_in  = 1'b1;
      end else if (item.active) begin
         if (invalid) begin
            consumed_in = 1'b1;
            action_in   = ACT_INVALID;
            if (item.mgmt) begin
               debt_in = debt_inc;
            end else if (item.meta && debt_nonzero) begin
               debt_in = debt_ff - 1'b1;
            end
         end else if (item.meta || (item.mgmt && item.ptp)) begin
            consumed_in = 1'b1;
            if (!item.vlan_ok) begin
               action_in = ACT_BAD_VLAN;
               if (item.meta) begin
                  flush_in = 1'b1;
                  debt_in  = '0;
               end else begin
                  debt_in = debt_inc;
               end
            end else if (item.meta) begin
               if (item.meta_full) begin
                  action_in = ACT_META_FULL;
                  flush_in  = 1'b1;
                  debt_in   = '0;
               end else begin
                  action_in = ACT_META_Q;
               end
            end else if (item.pkt_full) begin
               action_in = ACT_PKT_FULL;
               debt_in   = debt_inc;
            end else begin
               action_in = ACT_PKT_Q;
               ns_in     = item.nanoseconds;
               sec_in    = item.seconds;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            debt_ff  <= debt_in;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         consumed_ff <= consumed_in;
         action_ff   <= action_in;
         flush_ff    <= flush_in;
         ns_ff       <= ns_in;
         sec_ff      <= sec_in;
      end
   end

   // The debt after the step is the one now held, seen through its low byte.
   assign debt_wide = {{DEBT_OUT_W{1'b0}}, debt_ff};

   assign rsp_valid             = valid_ff;
   assign rsp_consumed          = consumed_ff;
   assign rsp_action            = action_ff;
   assign rsp_flush_queues      = flush_ff;
   assign rsp_stamp_nanoseconds = ns_ff;
   assign rsp_stamp_seconds     = sec_ff;
   assign rsp_debt_after        = debt_wide[DEBT_OUT_W-1:0];

endmodule

>>> rtl/ptp_mff_checker.sv
// Port-level checker for the PTP META frame filter and its bind statement.
`include "ptp_meta_frame_filter_defines.svh"

module ptp_mff_checker
   import ptp_mff_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_consumed,
   input logic [ACTION_W-1:0]   rsp_action,
   input logic                  rsp_flush_queues,
   input logic [NS_W-1:0]       rsp_stamp_nanoseconds,
   input logic [SEC_W-1:0]      rsp_stamp_seconds,
   input logic [DEBT_OUT_W-1:0] rsp_debt_after
);

   // A stalled response stays up with the same decision.
   `PTP_MFF_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_action) && $stable(rsp_debt_after))

   // A flush request always empties the queues and clears the debt.
   `PTP_MFF_ASSERT_NOW(a_flush_clears, clock, reset,
      rsp_valid && rsp_action == ACT_FLUSHED,
      rsp_flush_queues && !rsp_consumed && rsp_debt_after == '0)

   // Flushing the receive queues always goes together with a cleared debt.
   `PTP_MFF_ASSERT_NOW(a_flush_debt, clock, reset,
      rsp_valid && rsp_flush_queues,
      rsp_debt_after == '0 && (rsp_action == ACT_FLUSHED ||
         rsp_action == ACT_META_FULL || rsp_action == ACT_BAD_VLAN))

   // Only a queued packet carries a timestamp.
   `PTP_MFF_ASSERT_NOW(a_stamp_only_queued, clock, reset,
      rsp_valid && rsp_action != ACT_PKT_Q,
      rsp_stamp_nanoseconds == '0 && rsp_stamp_seconds == '0)

   // Pass and flush are the only decisions that leave the frame to the caller.
   `PTP_MFF_ASSERT_NOW(a_consumed_action, clock, reset,
      rsp_valid && !rsp_consumed,
      rsp_action == ACT_PASS || rsp_action == ACT_FLUSHED)

endmodule

bind ptp_meta_frame_filter ptp_mff_checker u_ptp_mff_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_consumed          (rsp_consumed),
   .rsp_action            (rsp_action),
   .rsp_flush_queues      (rsp_flush_queues),
   .rsp_stamp_nanoseconds (rsp_stamp_nanoseconds),
   .rsp_stamp_seconds     (rsp_stamp_seconds),
   .rsp_debt_after        (rsp_debt_after)
);
